>>> rtl/core/region_map_page_descriptor_builder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the region map descriptor builder
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REGION_MAP_PAGE_DESCRIPTOR_BUILDER_TOP_DEFINES_SVH
`define REGION_MAP_PAGE_DESCRIPTOR_BUILDER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RMPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmpd check failed");

// next-cycle implication checked outside reset
`define RMPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmpd check failed");

`endif

>>> rtl/core/rmpd_pkg.sv
// ----------------------------------------------------------------------------
// rmpd_pkg
// Types and constants for the region map descriptor builder.
// ----------------------------------------------------------------------------
package rmpd_pkg;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_TABLE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // one table entry
  typedef struct packed {
    logic [31:0] vbase;
    logic [31:0] pbase;
    logic [32:0] len;
    logic [2:0]  attr;
  } region_t;

  // short-descriptor leaf entry
  function automatic logic [31:0] leaf_entry(input logic [2:0] attr,
                                             input logic [31:0] pa,
                                             input logic lvl1);
    logic rw;
    logic mem;
    logic xn;
    logic [31:0] d;
    rw  = attr[1];
    mem = attr[0];
    xn  = rw | ~mem;
    if (lvl1) begin
      d = 32'h0001_0402;
      if (attr[2]) d = d | 32'h0008_0000;
      if (!rw) d = d | 32'h0000_8000;
      if (mem) d = d | 32'h0000_0004;
      if (xn) d = d | 32'h0000_0010;
      d = d | (pa & 32'hFFF0_0000);
    end else begin
      d = 32'h0000_0412;
      if (!rw) d = d | 32'h0000_0200;
      if (mem) d = d | 32'h0000_0004;
      if (xn) d = d | 32'h0000_0001;
      d = d | (pa & 32'hFFFF_F000);
    end
    return d;
  endfunction

endpackage

>>> rtl/core/region_map_page_descriptor_builder_top.sv
// ----------------------------------------------------------------------------
// region_map_page_descriptor_builder_top
// Sorted region table with short-descriptor entry builder.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_*) carry an insert (mode 0) or a query (mode 1). Each
//   word yields exactly one result word (out_status, out_descriptor).
//   The region table sits in one synchronous memory, one entry per cycle.
//   An insert scans for the slot, then shifts the tail up one entry at a time
//   (a read state then a write state per entry) and writes the new entry. A
//   query walks the sorted entries from the start until it can decide.
//   The next word can be accepted the cycle after the result loads.
//   One item is in work at a time; in_stall is high while busy.
//   A result waits in an output register while out_stall is high; the next
//   word is accepted once the register is free or being drained.
//   Reset empties the table (count to zero); memory contents need no clear
//   because entries at or past the count are never used.
// ----------------------------------------------------------------------------
module region_map_page_descriptor_builder_top #(
  parameter int MAX_REGIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_va,
  input  logic [31:0] in_pa,
  input  logic [32:0] in_size,
  input  logic [2:0]  in_attr_flags,
  input  logic [1:0]  in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_descriptor
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_RESP
  } state_t;

  // table memory
  rmpd_pkg::region_t mem [MAX_REGIONS];
  rmpd_pkg::region_t rd_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  rmpd_pkg::region_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;      // entry whose data appears on rd_q
  logic          rdv_r;      // rd_q holds entry idx_r
  logic          mode_r;
  logic [31:0]   va_r;
  logic [31:0]   pa_r;
  logic [32:0]   size_r;
  logic [2:0]   attr_r;
  logic          lvl1_r;
  // query progress
  logic          phase_r;    // 0 find first, 1 inner walk
  logic [2:0]    iattr_r;
  logic [31:0]   fvb_r;
  logic [31:0]   fpb_r;
  logic          fns_r;
  logic [CW-1:0] pos_r;
  logic          ov_r;
  logic [1:0]    ost_r;
  logic [31:0]   odesc_r;

  // area bounds (33 bits, no wrap)
  logic [32:0] abase;
  logic [32:0] aend;
  assign abase = lvl1_r ? {1'b0, va_r[31:20], 20'd0} : {1'b0, va_r[31:12], 12'd0};
  assign aend  = lvl1_r ? (abase + 33'h000F_FFFF) : (abase + 33'h0000_0FFF);

  // current entry bounds
  logic [33:0] rb;
  logic [33:0] rend;  // exclusive end
  logic [33:0] rlast;
  assign rb    = {2'b00, rd_q.vbase};
  assign rend  = rb + {1'b0, rd_q.len};
  assign rlast = rend - 34'd1;

  logic last_idx;
  assign last_idx = (idx_r + CW'(1)) >= count_r;

  assign in_stall  = (state_r != S_IDLE) || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_descriptor = odesc_r;

  // read address and write port control
  always_comb begin
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos_r[AW-1:0];
    wr_data = rd_q;
    unique case (state_r)
      S_SCAN:     if (rdv_r) rd_addr = AW'(idx_r + CW'(1));
                  else rd_addr = idx_r[AW-1:0];
      S_SHIFT_RD: rd_addr = AW'(idx_r - CW'(1));
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_q;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = '{vbase: va_r, pbase: pa_r, len: size_r, attr: attr_r};
      end
      default: rd_addr = idx_r[AW-1:0];
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      if (ov_r && !out_stall && state_r != S_RESP) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            mode_r  <= in_mode;
            va_r    <= in_va;
            pa_r    <= in_pa;
            size_r  <= in_size;
            attr_r  <= in_attr_flags;
            lvl1_r  <= (in_level == 2'd1);
            idx_r   <= '0;
            rdv_r   <= 1'b0;
            phase_r <= 1'b0;
            ost_r   <= rmpd_pkg::ST_DONE;
            odesc_r <= '0;
            if (in_mode == rmpd_pkg::MODE_INSERT) begin
              if (in_size == '0) state_r <= S_RESP;
              else if (count_r >= CW'(MAX_REGIONS)) begin
                ost_r   <= rmpd_pkg::ST_FULL;
                state_r <= S_RESP;
              end else if (count_r == '0) begin
                pos_r   <= '0;
                state_r <= S_WRITE;
              end else state_r <= S_SCAN;
            end else begin
              ost_r <= rmpd_pkg::ST_UNMAPPED;
              if ((in_level != 2'd1 && in_level != 2'd2) || count_r == '0)
                state_r <= S_RESP;
              else state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!rdv_r) begin
            rdv_r <= 1'b1;
          end else if (mode_r == rmpd_pkg::MODE_INSERT) begin
            // first slot where vbase > va, or equal and len <= size
            if (rd_q.vbase > va_r || (rd_q.vbase == va_r && rd_q.len <= size_r)) begin
              pos_r   <= idx_r;
              idx_r   <= count_r;
              state_r <= S_SHIFT_RD;
            end else if (last_idx) begin
              pos_r   <= count_r;
              idx_r   <= count_r;
              state_r <= S_WRITE;
            end else idx_r <= idx_r + CW'(1);
          end else if (!phase_r) begin
            // first region ending past the area base
            if (rend > {1'b0, abase}) begin
              if (rb > {1'b0, aend}) begin
                state_r <= S_RESP;
              end else if (rb <= {1'b0, abase} && rlast >= {1'b0, aend}) begin
                phase_r <= 1'b1;
                iattr_r <= rd_q.attr;
                fvb_r   <= rd_q.vbase;
                fpb_r   <= rd_q.pbase;
                fns_r   <= rd_q.attr[2];
                if (last_idx) begin
                  ost_r   <= rmpd_pkg::ST_DONE;
                  odesc_r <= rmpd_pkg::leaf_entry(rd_q.attr,
                    abase[31:0] - rd_q.vbase + rd_q.pbase, lvl1_r);
                  state_r <= S_RESP;
                end else idx_r <= idx_r + CW'(1);
              end else begin
                ost_r   <= rmpd_pkg::ST_TABLE;
                odesc_r <= rd_q.attr[2] ? 32'h9 : 32'h1;
                state_r <= S_RESP;
              end
            end else if (last_idx) begin
              state_r <= S_RESP;
            end else idx_r <= idx_r + CW'(1);
          end else begin
            // inner walk
            if (rb > {1'b0, aend}) begin
              ost_r   <= rmpd_pkg::ST_DONE;
              odesc_r <= rmpd_pkg::leaf_entry(iattr_r, abase[31:0] - fvb_r + fpb_r, lvl1_r);
              state_r <= S_RESP;
            end else if (rlast < {1'b0, abase} || rd_q.attr == iattr_r ||
                         (rb <= {1'b0, abase} && rlast >= {1'b0, aend})) begin
              logic [2:0] na;
              na = (rlast < {1'b0, abase}) ? iattr_r : rd_q.attr;
              iattr_r <= na;
              if (last_idx) begin
                ost_r   <= rmpd_pkg::ST_DONE;
                odesc_r <= rmpd_pkg::leaf_entry(na, abase[31:0] - fvb_r + fpb_r, lvl1_r);
                state_r <= S_RESP;
              end else idx_r <= idx_r + CW'(1);
            end else begin
              ost_r   <= rmpd_pkg::ST_TABLE;
              odesc_r <= fns_r ? 32'h9 : 32'h1;
              state_r <= S_RESP;
            end
          end
        end
        S_SHIFT_RD: begin
          if (idx_r == pos_r) state_r <= S_WRITE;
          else state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r   <= idx_r - CW'(1);
          state_r <= S_SHIFT_RD;
        end
        S_WRITE: begin
          count_r <= count_r + CW'(1);
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!ov_r || !out_stall) begin
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/rmpd_checker.sv
// ----------------------------------------------------------------------------
// rmpd_checker
// Port-level checks for the region map descriptor builder.
// ----------------------------------------------------------------------------
`include "region_map_page_descriptor_builder_top_defines.svh"

module rmpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_descriptor
);

  // an accepted word blocks the next one: in_stall rises in the cycle after
  `RMPD_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
  // a stalled result word holds
  `RMPD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_descriptor))
  // table-needed results carry only the table type and NS bits
  `RMPD_ASSERT_IMP(a_table_bits, clk, rst_n, out_valid && out_status == rmpd_pkg::ST_TABLE,
    out_descriptor == 32'h1 || out_descriptor == 32'h9)
  // unmapped and full results carry a zero entry
  `RMPD_ASSERT_IMP(a_zero_desc, clk, rst_n, out_valid && (out_status == rmpd_pkg::ST_UNMAPPED || out_status == rmpd_pkg::ST_FULL), out_descriptor == 32'h0)

endmodule

bind region_map_page_descriptor_builder_top rmpd_checker u_rmpd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_descriptor(out_descriptor)
);
